// ----- rtl/core/dq_pkg.sv -----
// dq_pkg: shared types and constants for the double-ended queue
// operation codes, result status codes and the control bundle passed between modules
// no dependencies
`default_nettype none

package dq_pkg;

    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // ring access issued for one item
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        status_t status;
    } dq_op_t;

endpackage

`default_nettype wire

// ----- rtl/core/dq_ram.sv -----
// dq_ram: generic single-write, single-read RAM with registered read data
// read data holds its value when no read is issued
// no dependencies
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dq_ctrl.sv -----
// dq_ctrl: front/rear pointers, element count and capacity figure of the ring
// decides per item whether it is refused and which ring entry is written or read
// depends on dq_pkg
`default_nettype none

module dq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [dq_pkg::KIND_W-1:0]     kind,
    output dq_pkg::dq_op_t                     op,
    output logic [$clog2(DEPTH)-1:0]           addr,
    output logic [$clog2(DEPTH+1)-1:0]         count_after,
    output logic [$clog2(DEPTH)+1-1:0]         cap_after
);

    import dq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = $clog2(DEPTH) + 1;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg,  rear_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] cap_reg,   cap_next;
    kind_t            op_kind;
    logic             is_push;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign op_kind = kind_t'(kind);
    assign is_push = op_kind inside {KIND_PUSH_FRONT, KIND_PUSH_REAR};

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        addr       = front_reg;
        op.wr_en   = 1'b0;
        op.rd_en   = 1'b0;
        op.status  = STATUS_DONE;

        if (accept)
        begin
            if (is_push)
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    op.status = STATUS_FULL;
                end
                else
                begin
                    if (CAP_W'(count_reg) == cap_reg)
                    begin
                        cap_next = cap_reg << 1;
                    end
                    // an empty ring places the first word on the shared slot
                    if (count_reg == '0)
                    begin
                        rear_next = front_reg;
                        addr      = front_reg;
                    end
                    else if (op_kind == KIND_PUSH_FRONT)
                    begin
                        front_next = ring_inc(front_reg);
                        addr       = front_next;
                    end
                    else
                    begin
                        rear_next = ring_dec(rear_reg);
                        addr      = rear_next;
                    end
                    count_next = count_reg + 1'b1;
                    op.wr_en   = 1'b1;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    op.status = STATUS_EMPTY;
                end
                else
                begin
                    // the last element leaves both pointers on its slot
                    if (op_kind == KIND_POP_FRONT)
                    begin
                        addr = front_reg;
                        if (count_reg > CNT_W'(1))
                        begin
                            front_next = ring_dec(front_reg);
                        end
                    end
                    else
                    begin
                        addr = rear_reg;
                        if (count_reg > CNT_W'(1))
                        begin
                            rear_next = ring_inc(rear_reg);
                        end
                    end
                    count_next = count_reg - 1'b1;
                    if ({CAP_W'(count_next), 1'b0} == {1'b0, cap_reg})
                    begin
                        cap_next = cap_reg >> 1;
                    end
                    op.rd_en = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_W'(1);
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    assign count_after = count_next;
    assign cap_after   = cap_next;

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue.sv -----
// double_ended_queue: bounded deque of signed words held in a ring RAM
// depends on dq_pkg, dq_ctrl and dq_ram
//
// Takes one item per cycle while in_stall is low and returns one result per item, in
// order: a push at either end, or a pop from either end. A pop on an empty queue and a
// push on a full ring (DEPTH words) are refused, flagged in status and change nothing.
// Each result carries the popped word (zero otherwise), the element count and the
// capacity figure after the item; both are reported modulo 32. A result passes the
// registered read port of the ring RAM, then the output register; out_stall can hold
// it in either. Pointer and count updates complete in the cycle of acceptance, so items
// may follow in every cycle unless stalled. The ring is not cleared after reset.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [dq_pkg::KIND_W-1:0]          kind,
    input  wire logic signed [dq_pkg::WORD_W-1:0]   push_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [dq_pkg::WORD_W-1:0]        pop_value,
    output logic [dq_pkg::STATUS_W-1:0]             status,
    output logic [dq_pkg::COUNT_W-1:0]              count,
    output logic [dq_pkg::COUNT_W-1:0]              nominal_capacity
);

    import dq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = $clog2(DEPTH) + 1;

    logic              accept;
    dq_op_t            op;
    logic [IDX_W-1:0]  addr;
    logic [CNT_W-1:0]  count_after;
    logic [CAP_W-1:0]  cap_after;
    logic [WORD_W-1:0] rd_data;

    // stage after the ring access, aligned with the RAM read data
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_pop_reg;
    status_t           s1_status_reg;
    logic [CNT_W-1:0]  s1_count_reg;
    logic [CAP_W-1:0]  s1_cap_reg;
    logic              s1_move;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] pop_value_reg;
    status_t           status_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CAP_W-1:0]  cap_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (kind),
        .op          (op),
        .addr        (addr),
        .count_after (count_after),
        .cap_after   (cap_after)
    );

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (op.wr_en),
        .wr_addr (addr),
        .wr_data (push_value),
        .rd_en   (op.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the RAM read data only changes on a new read, so it stays aligned with stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_reg    <= op.rd_en;
            s1_status_reg <= op.status;
            s1_count_reg  <= count_after;
            s1_cap_reg    <= cap_after;
        end
        if (s1_move)
        begin
            pop_value_reg <= s1_pop_reg ? rd_data : '0;
            status_reg    <= s1_status_reg;
            count_reg     <= s1_count_reg;
            cap_reg       <= s1_cap_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pop_value        = pop_value_reg;
    assign status           = status_reg;
    assign count            = COUNT_W'(count_reg);
    assign nominal_capacity = COUNT_W'(cap_reg);

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({op.wr_en, op.rd_en}))
        else $error("ring written and read for the same item");

    a_refused_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op.status != STATUS_DONE |-> !op.wr_en && !op.rd_en)
        else $error("refused item touched the ring");

    a_cap_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot(s1_cap_reg))
        else $error("capacity figure is not a power of two");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond ring depth");

    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !s1_pop_reg |=> pop_value == '0)
        else $error("nonzero word on a result without a pop");

endmodule

`default_nettype wire

// ----- verif/tb_double_ended_queue.sv -----
// tb_double_ended_queue: self-checking testbench for the double-ended queue
// depends on dq_pkg and double_ended_queue; a scoreboard class predicts every result
// directed end cases first, then random fill, drain and mixed runs with random idling

module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ITEM_TOTAL  = 550;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 10;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_mix_t;

    class deque_scoreboard;
        typedef struct {
            logic signed [WORD_W-1:0]  word;
            status_t                   st;
            logic [COUNT_W-1:0]        cnt;
            logic [COUNT_W-1:0]        cap;
        } deque_result_t;

        logic [WORD_W-1:0] ring_words [DEPTH];
        int unsigned       head_idx;
        int unsigned       tail_idx;
        int unsigned       held;
        int unsigned       cap_fig;
        deque_result_t     pending_results [$];
        int                mismatches;
        int                results_seen;

        function new();
            head_idx     = 0;
            tail_idx     = 0;
            held         = 0;
            cap_fig      = 1;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // work out the result of one accepted item and queue it
        function void note_item(kind_t op, logic signed [WORD_W-1:0] value);
            deque_result_t r;
            r.word = '0;
            r.st   = STATUS_DONE;
            if (op == KIND_PUSH_FRONT || op == KIND_PUSH_REAR)
            begin
                if (held >= DEPTH)
                begin
                    r.st = STATUS_FULL;
                end
                else
                begin
                    if (held == cap_fig)
                        cap_fig = cap_fig * 2;
                    if (held == 0)
                    begin
                        tail_idx = head_idx;
                        ring_words[head_idx] = value;
                    end
                    else if (op == KIND_PUSH_FRONT)
                    begin
                        head_idx = (head_idx + 1) % DEPTH;
                        ring_words[head_idx] = value;
                    end
                    else
                    begin
                        tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                        ring_words[tail_idx] = value;
                    end
                    held++;
                end
            end
            else if (held == 0)
            begin
                r.st = STATUS_EMPTY;
            end
            else
            begin
                // indices stay put when the last element leaves
                if (op == KIND_POP_FRONT)
                begin
                    r.word = ring_words[head_idx];
                    if (held > 1)
                        head_idx = (head_idx + DEPTH - 1) % DEPTH;
                end
                else
                begin
                    r.word = ring_words[tail_idx];
                    if (held > 1)
                        tail_idx = (tail_idx + 1) % DEPTH;
                end
                held--;
                if (2 * held == cap_fig)
                    cap_fig = cap_fig / 2;
            end
            r.cnt = COUNT_W'(held);
            r.cap = COUNT_W'(cap_fig);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("[%0t] result %0d: %s got %0h expected %0h",
                     $time, results_seen, what, got, want);
            mismatches++;
        endtask

        task check_result(logic signed [WORD_W-1:0] word, logic [STATUS_W-1:0] st,
                          logic [COUNT_W-1:0] cnt, logic [COUNT_W-1:0] cap);
            deque_result_t e;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no item pending, pop_value", word, '0);
                return;
            end
            e = pending_results.pop_front();
            if (word !== e.word)
                report_mismatch("pop_value", word, e.word);
            if (st !== e.st)
                report_mismatch("status", WORD_W'(st), WORD_W'(e.st));
            if (cnt !== e.cnt)
                report_mismatch("count", WORD_W'(cnt), WORD_W'(e.cnt));
            if (cap !== e.cap)
                report_mismatch("nominal_capacity", WORD_W'(cap), WORD_W'(e.cap));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic [KIND_W-1:0]           kind       = '0;
    logic signed [WORD_W-1:0]    push_value = '0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic signed [WORD_W-1:0]    pop_value;
    logic [STATUS_W-1:0]         status;
    logic [COUNT_W-1:0]          count;
    logic [COUNT_W-1:0]          nominal_capacity;

    bit                          calm = 1'b0;
    deque_scoreboard             deque_tracker = new();

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .push_value       (push_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pop_value        (pop_value),
        .status           (status),
        .count            (count),
        .nominal_capacity (nominal_capacity)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send_item(kind_t op, logic signed [WORD_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= op;
        push_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deque_tracker.note_item(op, value);
    endtask

    // result side: check what was taken at this edge, then pick the next stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            deque_tracker.check_result(pop_value, status, count, nominal_capacity);
        out_stall <= !calm && ($urandom_range(0, 99) < 23);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int                        sent;
        int                        run_len;
        int                        push_pct;
        bit                        is_push;
        traffic_mix_t              mix;
        kind_t                     op;
        logic signed [WORD_W-1:0]  value;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // pops on an empty queue
        send_item(KIND_POP_FRONT, 32'sh1234_5678);
        send_item(KIND_POP_REAR, -32'sd1);
        // popping the only element, from each end
        send_item(KIND_PUSH_REAR, 32'sh7FFF_FFFF);
        send_item(KIND_POP_FRONT, '0);
        send_item(KIND_PUSH_FRONT, 32'sh8000_0000);
        send_item(KIND_POP_REAR, '0);
        // fill to the brim, the rear index wrapping, then refused pushes
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 4)
                0: value = 32'sh7FFF_FFFF;
                1: value = 32'sh8000_0000;
                2: value = -32'sd1;
                default: value = $urandom;
            endcase
            send_item(i[0] ? KIND_PUSH_REAR : KIND_PUSH_FRONT, value);
        end
        send_item(KIND_PUSH_FRONT, 32'sh5555_5555);
        send_item(KIND_PUSH_REAR, 32'shAAAA_AAAA);

        // runs biased toward filling, draining or neither
        sent = 0;
        while (sent < ITEM_TOTAL)
        begin
            mix      = traffic_mix_t'($urandom_range(0, 2));
            run_len  = $urandom_range(6, 40);
            push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
            for (int i = 0; i < run_len && sent < ITEM_TOTAL; i++)
            begin
                calm    = (sent >= 200 && sent < 330);
                is_push = $urandom_range(0, 99) < push_pct;
                op      = kind_t'({!is_push, 1'($urandom_range(0, 1))});
                case ($urandom_range(0, 9))
                    0: value = 32'sh7FFF_FFFF;
                    1: value = 32'sh8000_0000;
                    2: value = '0;
                    3: value = -32'sd1;
                    default: value = $urandom;
                endcase
                send_item(op, value);
                sent++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (deque_tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (deque_tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- double_ended_queue.f -----
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue.sv
verif/tb_double_ended_queue.sv
